FILE: src/exact_npn_canonizer_unit_assert.svh
// assertion macros for the npn canoniser, clocked on clk and disabled in reset
`ifndef EXACT_NPN_CANONIZER_UNIT_ASSERT_SVH
`define EXACT_NPN_CANONIZER_UNIT_ASSERT_SVH

// condition implies consequent in the same cycle
`define NPNC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequent in the next cycle
`define NPNC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/npnc_pkg.sv
// shared types, constants and truth-table functions of the npn canoniser
package npnc_pkg;

	localparam int MAX_VARS = 6;
	localparam int TT_W     = 64;
	localparam int NV_W     = 3;
	localparam int VAR_W    = 3;
	localparam int PHASE_W  = 6;
	localparam int SWAP_W   = 10;
	localparam int CNT_W    = 4;

	// shared unit operations
	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_LOAD = 2'd1;
	localparam logic [1:0] OP_SWAP = 2'd2;
	localparam logic [1:0] OP_FLIP = 2'd3;

	typedef logic [VAR_W-1:0] var_idx_t;
	typedef var_idx_t [MAX_VARS-1:0] perm_t;

	typedef struct packed {
		logic [1:0]      op;
		var_idx_t        pos;
		var_idx_t        flip_sel;
		logic [NV_W-1:0] nv;
	} unit_ctl_t;

	typedef struct packed {
		logic clear;
		logic step;
	} sched_ctl_t;

	localparam logic [TT_W-1:0] ADJ_MASK [5] = '{
		64'h2222222222222222, 64'h0C0C0C0C0C0C0C0C, 64'h00F000F000F000F0,
		64'h0000FF000000FF00, 64'h00000000FFFF0000
	};
	localparam logic [TT_W-1:0] COF0_MASK [6] = '{
		64'h5555555555555555, 64'h3333333333333333, 64'h0F0F0F0F0F0F0F0F,
		64'h00FF00FF00FF00FF, 64'h0000FFFF0000FFFF, 64'h00000000FFFFFFFF
	};

	function automatic logic [TT_W-1:0] table_mask(input logic [NV_W-1:0] nv);
		logic [6:0] w;
		w = 7'd1 << nv;
		if (nv >= 3'(MAX_VARS)) begin
			return '1;
		end
		return (64'd1 << w) - 64'd1;
	endfunction

	// exchange variables p and p+1
	function automatic logic [TT_W-1:0] swap_adj(input logic [TT_W-1:0] t, input var_idx_t p);
		logic [TT_W-1:0] m;
		logic [6:0]      s;
		m = '0;
		s = 7'd1 << p;
		case (p)
			3'd0: m = ADJ_MASK[0];
			3'd1: m = ADJ_MASK[1];
			3'd2: m = ADJ_MASK[2];
			3'd3: m = ADJ_MASK[3];
			3'd4: m = ADJ_MASK[4];
			default: m = '0;
		endcase
		if (p > 3'd4) begin
			return t;
		end
		return (t & ~(m | (m << s))) | ((t & m) << s) | ((t >> s) & m);
	endfunction

	// complement variable v
	function automatic logic [TT_W-1:0] flip_in(input logic [TT_W-1:0] t, input var_idx_t v);
		logic [TT_W-1:0] m;
		logic [6:0]      s;
		m = '0;
		s = 7'd1 << v;
		case (v)
			3'd0: m = COF0_MASK[0];
			3'd1: m = COF0_MASK[1];
			3'd2: m = COF0_MASK[2];
			3'd3: m = COF0_MASK[3];
			3'd4: m = COF0_MASK[4];
			3'd5: m = COF0_MASK[5];
			default: m = '0;
		endcase
		if (v > 3'd5) begin
			return t;
		end
		return ((t & m) << s) | ((t >> s) & m);
	endfunction

	// number of adjacent swaps in one permutation sweep
	function automatic logic [SWAP_W-1:0] swaps_per_sweep(input logic [NV_W-1:0] nv);
		logic [SWAP_W-1:0] r;
		case (nv)
			3'd2: r = 10'd1;
			3'd3: r = 10'd5;
			3'd4: r = 10'd23;
			3'd5: r = 10'd119;
			default: r = 10'd719;
		endcase
		return r;
	endfunction

	function automatic perm_t ident_perm();
		perm_t p;
		for (int i = 0; i < MAX_VARS; i++) begin
			p[i] = VAR_W'(i);
		end
		return p;
	endfunction

endpackage

FILE: src/npnc_if.sv
// valid/ready channels of the npn canoniser: input items and results
interface npnc_in_if;
	import npnc_pkg::*;
	logic            valid;
	logic            ready;
	logic [TT_W-1:0] truth_table;
	logic [NV_W-1:0] var_count;
	modport source(output valid, truth_table, var_count, input ready);
	modport sink(input valid, truth_table, var_count, output ready);
endinterface

interface npnc_out_if;
	import npnc_pkg::*;
	logic               valid;
	logic               ready;
	logic [TT_W-1:0]    canon_table;
	logic [PHASE_W-1:0] input_phase;
	logic               output_negated;
	logic [VAR_W-1:0]   perm_0;
	logic [VAR_W-1:0]   perm_1;
	logic [VAR_W-1:0]   perm_2;
	logic [VAR_W-1:0]   perm_3;
	logic [VAR_W-1:0]   perm_4;
	logic [VAR_W-1:0]   perm_5;
	logic               unsupported;
	modport source(output valid, canon_table, input_phase, output_negated, perm_0, perm_1,
		perm_2, perm_3, perm_4, perm_5, unsupported, input ready);
	modport sink(input valid, canon_table, input_phase, output_negated, perm_0, perm_1,
		perm_2, perm_3, perm_4, perm_5, unsupported, output ready);
endinterface

FILE: src/npnc_sched.sv
// adjacent-swap schedule generator and live permutation tracker
module npnc_sched (
	input  logic                    clk,
	input  logic                    arst_n,
	input  npnc_pkg::sched_ctl_t    ctl,
	input  logic [npnc_pkg::NV_W-1:0] nv,
	output npnc_pkg::var_idx_t      pos,
	output npnc_pkg::perm_t         perm_next
);
	import npnc_pkg::*;

	// one mixed-radix digit per level, each counts 0 .. 2m-1
	logic [CNT_W-1:0] cnt_q [3:6];
	logic [CNT_W-1:0] cnt_d [3:6];
	perm_t            perm_q;

	always_comb begin
		logic             carry;
		logic [CNT_W-1:0] nc;
		var_idx_t         base;
		var_idx_t         add;
		carry = 1'b1;
		base  = '0;
		add   = '0;
		nc    = '0;
		for (int m = 3; m <= 6; m++) begin
			cnt_d[m] = cnt_q[m];
		end
		for (int m = 6; m >= 3; m--) begin
			if (m <= int'(nv) && carry) begin
				nc = (cnt_q[m] == CNT_W'(2 * m - 1)) ? '0 : cnt_q[m] + 4'd1;
				cnt_d[m] = nc;
				if (nc == CNT_W'(m)) begin
					add = add + 3'd1;
				end else if (nc != '0) begin
					carry = 1'b0;
					base  = (nc < CNT_W'(m)) ? VAR_W'(CNT_W'(m - 1) - nc)
						: VAR_W'(nc - CNT_W'(m + 1));
				end
			end
		end
		pos = base + add;
	end

	always_comb begin
		perm_next = perm_q;
		if (ctl.clear) begin
			perm_next = ident_perm();
		end else if (ctl.step) begin
			for (int i = 0; i < MAX_VARS - 1; i++) begin
				if (pos == VAR_W'(i)) begin
					perm_next[i]     = perm_q[i + 1];
					perm_next[i + 1] = perm_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 3; m <= 6; m++) begin
				cnt_q[m] <= '0;
			end
			perm_q <= ident_perm();
		end else begin
			if (ctl.clear) begin
				for (int m = 3; m <= 6; m++) begin
					cnt_q[m] <= '0;
				end
			end else if (ctl.step) begin
				cnt_q <= cnt_d;
			end
			perm_q <= perm_next;
		end
	end

endmodule

FILE: src/npnc_unit.sv
// shared transform and compare unit: walks the table and keeps the minimum
module npnc_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  npnc_pkg::unit_ctl_t       ctl,
	input  logic [npnc_pkg::TT_W-1:0] load_table,
	output logic                      better,
	output logic [npnc_pkg::TT_W-1:0] best_table,
	output logic                      best_inverted
);
	import npnc_pkg::*;

	logic [TT_W-1:0] work_q;
	logic [TT_W-1:0] best_q;
	logic            best_inv_q;
	logic [TT_W-1:0] mask;
	logic [TT_W-1:0] cand;
	logic [TT_W-1:0] lo;
	logic [5:0]      top_idx;
	logic            cand_msb;

	assign mask    = table_mask(ctl.nv);
	assign top_idx = 6'((7'd1 << ctl.nv) - 7'd1);

	always_comb begin
		case (ctl.op)
			OP_LOAD: cand = load_table & mask;
			OP_SWAP: cand = swap_adj(work_q, ctl.pos) & mask;
			OP_FLIP: cand = flip_in(swap_adj(work_q, '0), ctl.flip_sel) & mask;
			default: cand = work_q;
		endcase
	end

	// the complement is smaller exactly when the top used bit is set
	assign cand_msb = cand[top_idx];
	assign lo       = cand_msb ? (~cand & mask) : cand;
	assign better   = (ctl.op == OP_SWAP || ctl.op == OP_FLIP) && (lo < best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q     <= '0;
			best_q     <= '0;
			best_inv_q <= 1'b0;
		end else begin
			if (ctl.op != OP_HOLD) begin
				work_q <= cand;
			end
			if (ctl.op == OP_LOAD || better) begin
				best_q     <= lo;
				best_inv_q <= cand_msb;
			end
		end
	end

	assign best_table    = best_q;
	assign best_inverted = best_inv_q;

endmodule

FILE: src/exact_npn_canonizer_unit.sv
// Exact NPN canoniser for 2 to 6 variables. One item is taken at a time: after acceptance the
// shared transform/compare unit walks every permutation (adjacent swaps) for every input
// polarity (Gray-code flips), one step per clock, then registers the best table as the result.
// The step rate is set by the single 64-bit swap/flip network and compare. Items with fewer
// than two variables give an unsupported result on the next cycle. The input is not ready
// while a search runs or while a result still waits to be taken and would be overwritten.
module exact_npn_canonizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	npnc_in_if.sink    item,
	npnc_out_if.source result
);
	import npnc_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SWEEP  = 2'd1;
	localparam logic [1:0] ST_FLIP   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]         state_q;
	logic [NV_W-1:0]    n_q;
	logic [SWAP_W-1:0]  sw_left_q;
	logic [PHASE_W-1:0] fl_left_q;
	logic [PHASE_W-1:0] flip_cnt_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] best_phase_q;
	perm_t              best_perm_q;

	logic               out_valid_q;
	logic [TT_W-1:0]    out_table_q;
	logic [PHASE_W-1:0] out_phase_q;
	logic               out_neg_q;
	perm_t              out_perm_q;
	logic               out_unsup_q;

	logic               accept;
	logic               supported;
	logic               out_load;
	logic [NV_W-1:0]    n_eff;
	logic [PHASE_W-1:0] flip_cnt_next;
	logic [PHASE_W-1:0] phase_next;
	var_idx_t           flip_v;
	unit_ctl_t          unit_ctl;
	sched_ctl_t         sched_ctl;
	var_idx_t           sched_pos;
	perm_t              perm_next;
	logic               unit_better;
	logic [TT_W-1:0]    unit_best;
	logic               unit_best_inv;
	logic [5:0]         top_idx;

	assign item.ready = (state_q == ST_IDLE) && (!out_valid_q || result.ready);
	assign accept     = item.valid && item.ready;
	assign supported  = item.var_count >= 3'd2;
	assign n_eff      = (item.var_count > NV_W'(MAX_VARS)) ? NV_W'(MAX_VARS) : item.var_count;
	assign top_idx    = 6'((7'd1 << n_q) - 7'd1);
	assign out_load   = (state_q == ST_IDLE && accept && !supported)
		|| (state_q == ST_FINISH && (!out_valid_q || result.ready));

	// gray-code flip: the variable is the lowest set bit of the new flip count
	assign flip_cnt_next = flip_cnt_q + 6'd1;
	always_comb begin
		flip_v = '0;
		for (int i = PHASE_W - 1; i >= 0; i--) begin
			if (flip_cnt_next[i]) begin
				flip_v = VAR_W'(i);
			end
		end
	end
	assign phase_next = phase_q ^ (6'd1 << flip_v);

	always_comb begin
		unit_ctl.op       = OP_HOLD;
		unit_ctl.pos      = sched_pos;
		unit_ctl.flip_sel = flip_v;
		unit_ctl.nv       = (state_q == ST_IDLE) ? n_eff : n_q;
		sched_ctl.clear   = 1'b0;
		sched_ctl.step    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && supported) begin
					unit_ctl.op     = OP_LOAD;
					sched_ctl.clear = 1'b1;
				end
			end
			ST_SWEEP: begin
				unit_ctl.op    = OP_SWAP;
				sched_ctl.step = 1'b1;
			end
			ST_FLIP: begin
				unit_ctl.op     = OP_FLIP;
				sched_ctl.clear = 1'b1;
			end
			default: begin
				unit_ctl.op = OP_HOLD;
			end
		endcase
	end

	npnc_sched u_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (sched_ctl),
		.nv        (n_q),
		.pos       (sched_pos),
		.perm_next (perm_next)
	);

	npnc_unit u_unit (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (unit_ctl),
		.load_table    (item.truth_table),
		.better        (unit_better),
		.best_table    (unit_best),
		.best_inverted (unit_best_inv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= '0;
			sw_left_q    <= '0;
			fl_left_q    <= '0;
			flip_cnt_q   <= '0;
			phase_q      <= '0;
			best_phase_q <= '0;
			best_perm_q  <= ident_perm();
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (unit_better) begin
				best_perm_q  <= perm_next;
				best_phase_q <= (state_q == ST_FLIP) ? phase_next : phase_q;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && supported) begin
						n_q          <= n_eff;
						sw_left_q    <= swaps_per_sweep(n_eff);
						fl_left_q    <= 6'((7'd1 << n_eff) - 7'd1);
						flip_cnt_q   <= '0;
						phase_q      <= '0;
						best_phase_q <= '0;
						best_perm_q  <= ident_perm();
						state_q      <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					sw_left_q <= sw_left_q - 10'd1;
					if (sw_left_q == 10'd1) begin
						state_q <= (fl_left_q == '0) ? ST_FINISH : ST_FLIP;
					end
				end
				ST_FLIP: begin
					fl_left_q  <= fl_left_q - 6'd1;
					flip_cnt_q <= flip_cnt_next;
					phase_q    <= phase_next;
					sw_left_q  <= swaps_per_sweep(n_q);
					state_q    <= ST_SWEEP;
				end
				default: begin
					if (!out_valid_q || result.ready) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && !supported) begin
			out_table_q <= '0;
			out_phase_q <= '0;
			out_neg_q   <= 1'b0;
			out_perm_q  <= '0;
			out_unsup_q <= 1'b1;
		end else if (state_q == ST_FINISH && (!out_valid_q || result.ready)) begin
			out_table_q <= unit_best;
			out_phase_q <= best_phase_q;
			out_neg_q   <= unit_best_inv;
			out_perm_q  <= best_perm_q;
			out_unsup_q <= 1'b0;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.canon_table    = out_table_q;
	assign result.input_phase    = out_phase_q;
	assign result.output_negated = out_neg_q;
	assign result.perm_0         = out_perm_q[0];
	assign result.perm_1         = out_perm_q[1];
	assign result.perm_2         = out_perm_q[2];
	assign result.perm_3         = out_perm_q[3];
	assign result.perm_4         = out_perm_q[4];
	assign result.perm_5         = out_perm_q[5];
	assign result.unsupported    = out_unsup_q;

`include "exact_npn_canonizer_unit_assert.svh"

	`NPNC_ASSERT_NEXT(a_busy_after_accept, item.valid && item.ready && item.var_count >= 3'd2,
		!item.ready, "input still ready after a search started")
	`NPNC_ASSERT_NEXT(a_best_never_grows, state_q == ST_SWEEP || state_q == ST_FLIP,
		unit_best <= $past(unit_best), "best table grew during the search")
	`NPNC_ASSERT_IMP(a_canon_top_clear, state_q == ST_FINISH, unit_best[top_idx] == 1'b0,
		"canonical table has its top used bit set")

endmodule

FILE: sim/exact_npn_canonizer_unit_tb.sv
// self-checking testbench of the exact npn canoniser: directed table, then random items
`timescale 1ns / 1ps

module exact_npn_canonizer_unit_tb;
	import npnc_pkg::*;

	typedef struct packed {
		logic [TT_W-1:0]    canon_table;
		logic [PHASE_W-1:0] input_phase;
		logic               output_negated;
		perm_t              perm;
		logic               unsupported;
	} npn_res_t;

	typedef struct packed {
		logic [TT_W-1:0] tt;
		logic [NV_W-1:0] nv;
		logic            typed;
		npn_res_t        res;
	} stim_row_t;

	localparam int N_DIRECTED = 20;
	localparam int N_RANDOM   = 80;

	logic clk;
	logic arst_n;

	npnc_in_if  item_ch();
	npnc_out_if res_ch();

	exact_npn_canonizer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch)
	);

	npn_res_t canon_q[$];
	int errors;
	int src_idle;
	int dst_idle;
	int per_nv[8];
	int results_seen;

	// predictor state, rebuilt for every item
	logic [63:0] plain_t, inv_t, best_t;
	logic        best_inv;
	int          best_swap_at, best_flip_at;
	int          swap_order[720];

	localparam logic [63:0] PAIR_M [5] = '{
		64'h2222222222222222, 64'h0C0C0C0C0C0C0C0C, 64'h00F000F000F000F0,
		64'h0000FF000000FF00, 64'h00000000FFFF0000
	};
	localparam logic [63:0] HALF_M [6] = '{
		64'h5555555555555555, 64'h3333333333333333, 64'h0F0F0F0F0F0F0F0F,
		64'h00FF00FF00FF00FF, 64'h0000FFFF0000FFFF, 64'h00000000FFFFFFFF
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] exchange_vars(logic [63:0] t, int p);
		int s;
		logic [63:0] m;
		if (p > 4) return t;
		s = 1 << p;
		m = PAIR_M[p];
		return (t & ~(m | (m << s))) | ((t & m) << s) | ((t >> s) & m);
	endfunction

	function automatic logic [63:0] negate_var(logic [63:0] t, int v);
		int s;
		logic [63:0] m;
		if (v > 5) return t;
		s = 1 << v;
		m = HALF_M[v];
		return ((t & m) << s) | ((t >> s) & m);
	endfunction

	function automatic int lowest_one(int x);
		int r;
		r = 0;
		if (x == 0) return 0;
		while ((x & 1) == 0) begin
			x = x >> 1;
			r++;
		end
		return r;
	endfunction

	function automatic void set_order(int idx, int total, int v);
		if (idx < total && idx < 720) swap_order[idx] = v;
	endfunction

	// steinhaus-johnson-trotter adjacent swap positions
	function automatic void build_order(int n, int fact);
		int total, d, k, m, j;
		total = fact - 1;
		d = fact / 2;
		for (int i = 0; i < 720; i++) swap_order[i] = 0;
		if (d == 0) return;
		set_order(d - 1, total, 0);
		m = 2;
		while (m < n) begin
			m++;
			d = d / m;
			if (d == 0) return;
			k = 0;
			do begin
				k += d;
				j = m - 1;
				while (j > 0) begin
					j--;
					set_order(k - 1, total, j);
					k += d;
				end
				if (k - 1 < total && k - 1 < 720) swap_order[k - 1]++;
				k += d;
				while (j < m - 1) begin
					set_order(k - 1, total, j);
					j++;
					k += d;
				end
			end while (k < fact);
		end
	endfunction

	function automatic bit improve_best();
		logic [63:0] lo;
		if (plain_t < best_t || inv_t < best_t) begin
			lo = (plain_t < inv_t) ? plain_t : inv_t;
			if (lo < best_t) best_t = lo;
			best_inv = (best_t == inv_t);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void walk_perms(logic [63:0] mask, int swap_total, int flip_idx);
		for (int st = swap_total; st > 0; st--) begin
			plain_t = exchange_vars(plain_t, swap_order[(st - 1) % 720]) & mask;
			inv_t   = exchange_vars(inv_t, swap_order[(st - 1) % 720]) & mask;
			if (improve_best()) begin
				best_swap_at = st - 1;
				best_flip_at = flip_idx;
			end
		end
	endfunction

	function automatic npn_res_t canonize_npn(logic [63:0] tt, logic [2:0] nv_in);
		npn_res_t r;
		int n, fact, swap_total, flip_total, v, tmp;
		int pm[6];
		logic [63:0] mask;
		logic [5:0] ph;
		r = '0;
		n = nv_in;
		if (n < 2) begin
			r.unsupported = 1'b1;
			return r;
		end
		if (n > 6) n = 6;
		mask = (n == 6) ? '1 : ((64'd1 << (1 << n)) - 64'd1);
		fact = 1;
		for (int k = 2; k <= n; k++) fact *= k;
		swap_total = fact - 1;
		flip_total = (1 << n) - 1;
		build_order(n, fact);
		plain_t = tt & mask;
		inv_t = ~plain_t & mask;
		best_t = (plain_t < inv_t) ? plain_t : inv_t;
		best_inv = (best_t == inv_t);
		best_swap_at = swap_total;
		best_flip_at = flip_total;
		walk_perms(mask, swap_total, flip_total);
		for (int fs = flip_total; fs > 0; fs--) begin
			v = lowest_one(flip_total - (fs - 1));
			plain_t = negate_var(exchange_vars(plain_t, 0), v) & mask;
			inv_t   = negate_var(exchange_vars(inv_t, 0), v) & mask;
			if (improve_best()) begin
				best_swap_at = swap_total;
				best_flip_at = fs - 1;
			end
			walk_perms(mask, swap_total, fs - 1);
		end
		for (int k = 0; k < 6; k++) pm[k] = k;
		for (int st = swap_total; st > best_swap_at; st--) begin
			v = swap_order[(st - 1) % 720];
			if (v < 5) begin
				tmp = pm[v];
				pm[v] = pm[v + 1];
				pm[v + 1] = tmp;
			end
		end
		ph = '0;
		for (int fs = flip_total; fs > best_flip_at; fs--) begin
			v = lowest_one(flip_total - (fs - 1));
			ph[v] = ~ph[v];
		end
		r.canon_table = best_t & mask;
		r.input_phase = ph;
		r.output_negated = best_inv;
		for (int k = 0; k < 6; k++) r.perm[k] = VAR_W'(pm[k]);
		r.unsupported = 1'b0;
		return r;
	endfunction

	task automatic send_item(logic [63:0] tt, logic [2:0] nv, logic typed, npn_res_t lit);
		while ($urandom_range(0, 99) < src_idle) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.truth_table <= tt;
		item_ch.var_count   <= nv;
		do @(posedge clk); while (!item_ch.ready);
		// transaction accepted at this edge
		canon_q.push_back(typed ? lit : canonize_npn(tt, nv));
		per_nv[nv]++;
	endtask

	function automatic logic [2:0] pick_nv();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return 3'd0;
		if (r < 8) return 3'd1;
		if (r < 30) return 3'd2;
		if (r < 60) return 3'd3;
		if (r < 84) return 3'd4;
		if (r < 97) return 3'd5;
		if (r < 99) return 3'd6;
		return 3'd7;
	endfunction

	function automatic npn_res_t ident_res(logic [63:0] t, logic neg);
		npn_res_t r;
		r = '0;
		r.canon_table = t;
		r.output_negated = neg;
		r.perm = ident_perm();
		return r;
	endfunction

	// receiver: check each result transaction, then choose the next ready
	always @(posedge clk or negedge arst_n) begin
		npn_res_t got, want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got.canon_table = res_ch.canon_table;
				got.input_phase = res_ch.input_phase;
				got.output_negated = res_ch.output_negated;
				got.perm = {res_ch.perm_5, res_ch.perm_4, res_ch.perm_3, res_ch.perm_2,
					res_ch.perm_1, res_ch.perm_0};
				got.unsupported = res_ch.unsupported;
				results_seen++;
				if (canon_q.size() == 0) begin
					$display("%0t: result with nothing expected: %h", $realtime, got);
					errors++;
				end else begin
					want = canon_q.pop_front();
					if (got.canon_table !== want.canon_table) begin
						$display("%0t: canon_table expected %h actual %h", $realtime,
							want.canon_table, got.canon_table);
						errors++;
					end
					if (got.input_phase !== want.input_phase) begin
						$display("%0t: input_phase expected %h actual %h", $realtime,
							want.input_phase, got.input_phase);
						errors++;
					end
					if (got.output_negated !== want.output_negated) begin
						$display("%0t: output_negated expected %b actual %b", $realtime,
							want.output_negated, got.output_negated);
						errors++;
					end
					if (got.perm !== want.perm) begin
						$display("%0t: perm expected %h actual %h", $realtime,
							want.perm, got.perm);
						errors++;
					end
					if (got.unsupported !== want.unsupported) begin
						$display("%0t: unsupported expected %b actual %b", $realtime,
							want.unsupported, got.unsupported);
						errors++;
					end
				end
			end
			res_ch.ready <= ($urandom_range(0, 99) >= dst_idle);
		end
	end

	initial begin
		#250ms;
		$display("timeout at %0t", $realtime);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		stim_row_t rows[N_DIRECTED];
		npn_res_t unsup;
		int waited;
		unsup = '0;
		unsup.unsupported = 1'b1;
		errors = 0;
		results_seen = 0;
		src_idle = 17;
		dst_idle = 47;
		for (int i = 0; i < 8; i++) per_nv[i] = 0;
		arst_n = 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.truth_table <= '0;
		item_ch.var_count <= '0;

		rows[0]  = '{64'h0, 3'd0, 1'b1, unsup};
		rows[1]  = '{64'hFFFFFFFFFFFFFFFF, 3'd1, 1'b1, unsup};
		rows[2]  = '{64'h0, 3'd2, 1'b1, ident_res(64'h0, 1'b0)};
		rows[3]  = '{64'hFFFFFFFFFFFFFFFF, 3'd6, 1'b1, ident_res(64'h0, 1'b1)};
		rows[4]  = '{64'h0, 3'd6, 1'b1, ident_res(64'h0, 1'b0)};
		rows[5]  = '{64'hFFFFFFFFFFFFFFF6, 3'd2, 1'b0, '0};  // stray high bits
		rows[6]  = '{64'h8, 3'd2, 1'b0, '0};
		rows[7]  = '{64'h7, 3'd2, 1'b0, '0};
		rows[8]  = '{64'hE8, 3'd3, 1'b0, '0};
		rows[9]  = '{64'h96, 3'd3, 1'b0, '0};
		rows[10] = '{64'h8000, 3'd4, 1'b0, '0};
		rows[11] = '{64'h0001, 3'd4, 1'b0, '0};
		rows[12] = '{64'hAAAAAAAA, 3'd5, 1'b0, '0};
		rows[13] = '{64'hFFFFFFFF00000000, 3'd5, 1'b0, '0};
		rows[14] = '{64'h8000000000000001, 3'd6, 1'b0, '0};
		rows[15] = '{64'h123456789ABCDEF0, 3'd7, 1'b0, '0};  // saturates to six
		rows[16] = '{64'h5555555555555555, 3'd3, 1'b0, '0};
		rows[17] = '{64'h0123, 3'd4, 1'b0, '0};
		rows[18] = '{64'h1, 3'd0, 1'b1, unsup};
		rows[19] = '{64'hC, 3'd2, 1'b0, '0};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_item(rows[i].tt, rows[i].nv, rows[i].typed, rows[i].res);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				src_idle = 47;
				dst_idle = 17;
			end else if (i == 2 * N_RANDOM / 3) begin
				src_idle = 0;
				dst_idle = 0;
			end
			send_item({$urandom, $urandom}, pick_nv(), 1'b0, '0);
		end
		item_ch.valid <= 1'b0;

		waited = 0;
		while (canon_q.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		if (canon_q.size() != 0) begin
			$display("%0d results never arrived", canon_q.size());
			errors++;
		end
		repeat (20) @(posedge clk);

		$display("%0d items, %0d results; by variable count 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
			N_DIRECTED + N_RANDOM, results_seen, per_nv[0], per_nv[1], per_nv[2],
			per_nv[3], per_nv[4], per_nv[5], per_nv[6], per_nv[7]);
		$display("stall mixes: sender and receiver idling swapped, then none");
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/npnc_pkg.sv
src/npnc_if.sv
src/npnc_sched.sv
src/npnc_unit.sv
src/exact_npn_canonizer_unit.sv
sim/exact_npn_canonizer_unit_tb.sv
